/* sv/arq_sender_window_core_assert.svh */
// assertion macros shared by the window core
`ifndef ARQ_SENDER_WINDOW_CORE_ASSERT_SVH
`define ARQ_SENDER_WINDOW_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ASW_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ASW_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/asw_pkg.sv */
package asw_pkg;

	// field widths of the channels and the configuration port
	localparam int OPCODE_W   = 2;
	localparam int ACK_W      = 6;
	localparam int NUM_W      = 6;
	localparam int MODE_W     = 2;
	localparam int WIN_LEN_W  = 4;
	localparam int TOTAL_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// register values after reset
	localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = 4'd4;
	localparam logic [TOTAL_W-1:0]   TOTAL_RST   = 7'd11;

	typedef enum logic [OPCODE_W-1:0] {
		OP_SEND    = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SAW  = 2'd0,
		MODE_GBN  = 2'd1,
		MODE_SR   = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE  = 2'd0,
		CFG_WIN   = 2'd1,
		CFG_TOTAL = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_SLIDE,
		ST_STATUS
	} state_t;

	// one result word
	typedef struct packed {
		logic             has_packet;
		logic [NUM_W-1:0] send_number;
		logic             last_of_run;
		logic             transfer_done;
	} res_word_t;

	// sequencer status seen by the top level
	typedef struct packed {
		logic idle;
		logic clearing;
		logic base_le_next;
		logic base_zero;
	} seq_stat_t;

endpackage

/* sv/asw_cmd_if.sv */
interface asw_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [asw_pkg::OPCODE_W-1:0] opcode;
	logic [asw_pkg::ACK_W-1:0]    ack_number;

	modport source (output valid, output opcode, output ack_number, input ready);
	modport sink (input valid, input opcode, input ack_number, output ready);
endinterface

/* sv/asw_res_if.sv */
interface asw_res_if;
	logic                      valid;
	logic                      ready;
	logic                      has_packet;
	logic [asw_pkg::NUM_W-1:0] send_number;
	logic                      last_of_run;
	logic                      transfer_done;

	modport source (output valid, output has_packet, output send_number, output last_of_run,
		output transfer_done, input ready);
	modport sink (input valid, input has_packet, input send_number, input last_of_run,
		input transfer_done, output ready);
endinterface

/* sv/asw_ack_ram.sv */
module asw_ack_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/asw_out_reg.sv */
module asw_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_vld,
	input  asw_pkg::res_word_t  push_word,
	output logic                out_free,
	asw_res_if.source           res
);

	logic               vld_q;
	asw_pkg::res_word_t word_q;

	assign out_free = !vld_q || res.ready;

	// output holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push_vld) begin
			vld_q <= 1'b1;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_vld) begin
			word_q <= push_word;
		end
	end

	assign res.valid         = vld_q;
	assign res.has_packet    = word_q.has_packet;
	assign res.send_number   = word_q.send_number;
	assign res.last_of_run   = word_q.last_of_run;
	assign res.transfer_done = word_q.transfer_done;

endmodule

/* sv/asw_seq.sv */
module asw_seq #(
	parameter int MAX_PACKETS = 64,
	parameter int PW          = 7,
	parameter int WW          = 4,
	parameter int AW          = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	asw_cmd_if.sink             cmd,
	input  asw_pkg::mode_t      mode,
	input  logic [PW-1:0]       total_eff,
	input  logic [WW-1:0]       win_eff,
	output logic                push_vld,
	output asw_pkg::res_word_t  push_word,
	input  logic                out_free,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output logic                ram_wdata,
	output logic                ram_re,
	output logic [AW-1:0]       ram_raddr,
	input  logic                ram_rdata,
	output asw_pkg::seq_stat_t  stat
);

	localparam int SW = ((PW > WW) ? PW : WW) + 1;
	localparam int KW = (PW > asw_pkg::ACK_W) ? PW : asw_pkg::ACK_W;

	asw_pkg::state_t state_q, state_d;
	asw_pkg::op_t    op_q;
	asw_pkg::op_t    op_in;

	logic [PW-1:0] base_q, next_q, cur_q, end_q;
	logic          s1_vld_q, pend_vld_q;
	logic [AW-1:0] s1_addr_q, pend_q;

	logic          accept;
	logic [SW-1:0] sum_x;
	logic [PW-1:0] nr, lim, base_inc, end_saw, end_gbn, end_sr, ack_inc;
	logic          base_lt_total;
	logic [KW-1:0] ack_k, base_k, nr_k, total_k, pend_k;
	logic          ack_in_total, saw_hit, gbn_hit;
	logic [AW-1:0] ack_a;
	logic          cand, emit_mid, scan_stall, cur_lt_end, scan_issue, scan_done;
	logic          cur_lt_total, slide_stop, slide_issue, clr_last;
	asw_pkg::res_word_t status_word, pend_word;

	assign op_in  = asw_pkg::op_t'(cmd.opcode);
	assign accept = cmd.valid && cmd.ready;

	// window limits and ack checks
	always_comb begin
		sum_x         = SW'(base_q) + SW'(win_eff);
		lim           = (sum_x < SW'(total_eff)) ? sum_x[PW-1:0] : total_eff;
		nr            = (next_q < base_q) ? base_q : next_q;
		base_lt_total = base_q < total_eff;
		base_inc      = base_q + PW'(1);
		end_saw       = base_lt_total ? base_inc : base_q;
		end_gbn       = (lim > nr) ? lim : nr;
		end_sr        = (lim > base_q) ? lim : base_q;
		ack_k         = KW'(cmd.ack_number);
		base_k        = KW'(base_q);
		nr_k          = KW'(nr);
		total_k       = KW'(total_eff);
		ack_in_total  = ack_k < total_k;
		saw_hit       = base_lt_total && (ack_k == base_k);
		gbn_hit       = (ack_k >= base_k) && (ack_k < nr_k) && ack_in_total;
		ack_inc       = ack_k[PW-1:0] + PW'(1);
		ack_a         = ack_k[AW-1:0];
	end

	// scan and slide pipeline conditions
	always_comb begin
		cand         = s1_vld_q && ((mode != asw_pkg::MODE_SR) || !ram_rdata);
		emit_mid     = cand && pend_vld_q;
		scan_stall   = emit_mid && !out_free;
		cur_lt_end   = cur_q < end_q;
		scan_issue   = !scan_stall && cur_lt_end;
		scan_done    = !s1_vld_q && !cur_lt_end;
		cur_lt_total = cur_q < total_eff;
		slide_stop   = (s1_vld_q && !ram_rdata) || (!s1_vld_q && !cur_lt_total);
		slide_issue  = cur_lt_total;
		clr_last     = cur_q == PW'(MAX_PACKETS - 1);
	end

	// result words
	always_comb begin
		pend_k                    = KW'(pend_q);
		status_word.has_packet    = 1'b0;
		status_word.send_number   = '0;
		status_word.last_of_run   = 1'b1;
		status_word.transfer_done = !base_lt_total;
		pend_word.has_packet      = 1'b1;
		pend_word.send_number     = pend_k[asw_pkg::NUM_W-1:0];
		pend_word.last_of_run     = 1'b0;
		pend_word.transfer_done   = !base_lt_total;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			asw_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = asw_pkg::ST_IDLE;
				end
			end
			asw_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					case (op_in)
						asw_pkg::OP_SEND: begin
							state_d = (mode == asw_pkg::MODE_NONE) ? asw_pkg::ST_STATUS
								: asw_pkg::ST_SCAN;
						end
						asw_pkg::OP_ACK: begin
							state_d = (mode == asw_pkg::MODE_SR && ack_in_total)
								? asw_pkg::ST_SLIDE : asw_pkg::ST_STATUS;
						end
						default: state_d = asw_pkg::ST_STATUS;
					endcase
				end
			end
			asw_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = asw_pkg::ST_FLUSH;
				end
			end
			asw_pkg::ST_FLUSH: begin
				if (out_free) begin
					state_d = asw_pkg::ST_IDLE;
				end
			end
			asw_pkg::ST_SLIDE: begin
				if (slide_stop) begin
					state_d = asw_pkg::ST_STATUS;
				end
			end
			asw_pkg::ST_STATUS: begin
				if (out_free) begin
					state_d = (op_q == asw_pkg::OP_RESTART) ? asw_pkg::ST_CLEAR
						: asw_pkg::ST_IDLE;
				end
			end
			default: state_d = asw_pkg::ST_IDLE;
		endcase
	end

	// outputs: handshake, memory ports and result pushes
	always_comb begin
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cur_q[AW-1:0];
		ram_wdata = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = cur_q[AW-1:0];
		push_vld  = 1'b0;
		push_word = status_word;
		case (state_q)
			asw_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
			end
			asw_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid && op_in == asw_pkg::OP_ACK && mode == asw_pkg::MODE_SR
					&& ack_in_total) begin
					ram_we    = 1'b1;
					ram_waddr = ack_a;
					ram_wdata = 1'b1;
				end
			end
			asw_pkg::ST_SCAN: begin
				ram_re    = scan_issue;
				push_vld  = emit_mid && out_free;
				push_word = pend_word;
			end
			asw_pkg::ST_FLUSH: begin
				push_vld = out_free;
				if (pend_vld_q) begin
					push_word             = pend_word;
					push_word.last_of_run = 1'b1;
				end
			end
			asw_pkg::ST_SLIDE: begin
				ram_re = !slide_stop && slide_issue;
			end
			asw_pkg::ST_STATUS: begin
				push_vld = out_free;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= asw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// window registers and scan cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= asw_pkg::OP_SEND;
			base_q     <= '0;
			next_q     <= '0;
			cur_q      <= '0;
			end_q      <= '0;
			s1_vld_q   <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				asw_pkg::ST_CLEAR: begin
					cur_q <= cur_q + PW'(1);
				end
				asw_pkg::ST_IDLE: begin
					if (accept) begin
						op_q       <= op_in;
						s1_vld_q   <= 1'b0;
						pend_vld_q <= 1'b0;
						case (op_in)
							asw_pkg::OP_RESTART: begin
								base_q <= '0;
								next_q <= '0;
							end
							asw_pkg::OP_SEND: begin
								case (mode)
									asw_pkg::MODE_SAW: begin
										cur_q  <= base_q;
										end_q  <= end_saw;
										next_q <= base_lt_total ? base_inc : nr;
									end
									asw_pkg::MODE_GBN: begin
										cur_q  <= nr;
										end_q  <= end_gbn;
										next_q <= end_gbn;
									end
									asw_pkg::MODE_SR: begin
										cur_q  <= base_q;
										end_q  <= end_sr;
										next_q <= end_sr;
									end
									default: next_q <= nr;
								endcase
							end
							asw_pkg::OP_ACK: begin
								case (mode)
									asw_pkg::MODE_SAW: begin
										if (saw_hit) begin
											base_q <= base_inc;
											next_q <= base_inc;
										end else begin
											next_q <= nr;
										end
									end
									asw_pkg::MODE_GBN: begin
										next_q <= nr;
										if (gbn_hit) begin
											base_q <= ack_inc;
										end
									end
									asw_pkg::MODE_SR: begin
										next_q <= nr;
										cur_q  <= base_q;
									end
									default: next_q <= nr;
								endcase
							end
							default: begin
								next_q <= (mode == asw_pkg::MODE_GBN) ? base_q : nr;
							end
						endcase
					end
				end
				asw_pkg::ST_SCAN: begin
					if (!scan_stall) begin
						if (cand) begin
							pend_vld_q <= 1'b1;
						end
						s1_vld_q <= scan_issue;
						if (scan_issue) begin
							cur_q <= cur_q + PW'(1);
						end
					end
				end
				asw_pkg::ST_SLIDE: begin
					if (slide_stop) begin
						s1_vld_q <= 1'b0;
						next_q   <= (next_q < base_q) ? base_q : next_q;
					end else begin
						if (s1_vld_q) begin
							base_q <= base_inc;
						end
						s1_vld_q <= slide_issue;
						if (slide_issue) begin
							cur_q <= cur_q + PW'(1);
						end
					end
				end
				asw_pkg::ST_STATUS: begin
					if (out_free && op_q == asw_pkg::OP_RESTART) begin
						cur_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// scan payload: address in flight and held candidate
	always_ff @(posedge clk) begin
		if (state_q == asw_pkg::ST_SCAN && !scan_stall) begin
			if (cand) begin
				pend_q <= s1_addr_q;
			end
			s1_addr_q <= cur_q[AW-1:0];
		end
	end

	assign stat.idle         = state_q == asw_pkg::ST_IDLE;
	assign stat.clearing     = state_q == asw_pkg::ST_CLEAR;
	assign stat.base_le_next = (base_q <= next_q) || (state_q == asw_pkg::ST_SLIDE);
	assign stat.base_zero    = base_q == '0;

endmodule

/* sv/arq_sender_window_core.sv */
// arq sender window: send rounds, acks, timeouts and restarts for three arq modes
// ack, timeout and mode-free events put their single word in the output stage once
// it is free; a send round scans the window slots, and a selective-repeat ack slides
// the base with one ack-map read per slot before its word; events go one at a time
// and the next word is taken the cycle after the last push, or after a restart's clearing pass
// reset: registers take their defaults and a clearing pass over all MAX_PACKETS entries wipes
`include "arq_sender_window_core_assert.svh"

module arq_sender_window_core #(
	parameter int MAX_PACKETS = 64,
	parameter int MAX_WINDOW  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [asw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [asw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	asw_cmd_if.sink                          cmd,
	asw_res_if.source                        res
);

	// the ack map with cmd.ready low; a restart runs the same pass after its word
	localparam int PW = $clog2(MAX_PACKETS + 1);
	localparam int WW = $clog2(MAX_WINDOW + 1);
	localparam int AW = $clog2(MAX_PACKETS);
	localparam int TW = (PW > asw_pkg::TOTAL_W) ? PW : asw_pkg::TOTAL_W;
	localparam int LW = (WW > asw_pkg::WIN_LEN_W) ? WW : asw_pkg::WIN_LEN_W;

	asw_pkg::mode_t                 mode_q;
	logic [asw_pkg::WIN_LEN_W-1:0]  win_len_q;
	logic [asw_pkg::TOTAL_W-1:0]    pkt_total_q;

	logic [TW-1:0]      total_x;
	logic [LW-1:0]      win_x;
	logic [PW-1:0]      total_eff;
	logic [WW-1:0]      win_eff;
	logic               push_vld, out_free;
	asw_pkg::res_word_t push_word;
	logic               ram_we, ram_wdata, ram_re, ram_rdata;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	asw_pkg::seq_stat_t stat;
	logic               restart_acc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= asw_pkg::MODE_SAW;
			win_len_q   <= asw_pkg::WIN_LEN_RST;
			pkt_total_q <= asw_pkg::TOTAL_RST;
		end else if (cfg_we) begin
			case (asw_pkg::cfg_idx_t'(cfg_index))
				asw_pkg::CFG_MODE:  mode_q <= asw_pkg::mode_t'(cfg_wdata[asw_pkg::MODE_W-1:0]);
				asw_pkg::CFG_WIN:   win_len_q <= cfg_wdata[asw_pkg::WIN_LEN_W-1:0];
				asw_pkg::CFG_TOTAL: pkt_total_q <= cfg_wdata[asw_pkg::TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp window and total into range
	always_comb begin
		total_x   = TW'(pkt_total_q);
		win_x     = LW'(win_len_q);
		total_eff = (total_x > TW'(MAX_PACKETS)) ? PW'(MAX_PACKETS) : total_x[PW-1:0];
		if (win_x == '0) begin
			win_eff = WW'(1);
		end else if (win_x > LW'(MAX_WINDOW)) begin
			win_eff = WW'(MAX_WINDOW);
		end else begin
			win_eff = win_x[WW-1:0];
		end
	end

	asw_seq #(
		.MAX_PACKETS (MAX_PACKETS),
		.PW          (PW),
		.WW          (WW),
		.AW          (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mode      (mode_q),
		.total_eff (total_eff),
		.win_eff   (win_eff),
		.push_vld  (push_vld),
		.push_word (push_word),
		.out_free  (out_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.stat      (stat)
	);

	asw_ack_ram #(
		.DEPTH (MAX_PACKETS),
		.AW    (AW)
	) u_ack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	asw_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (push_vld),
		.push_word (push_word),
		.out_free  (out_free),
		.res       (res)
	);

	// restart word taken this cycle
	assign restart_acc = cmd.valid && cmd.ready && (cmd.opcode == asw_pkg::OP_RESTART);

	// checks on the sequencer and output stage
	`ASW_ASSERT_IMP(a_no_word_in_clear, clk, arst_n, stat.clearing, !cmd.ready, "taken in clear")
	`ASW_ASSERT_IMP(a_base_le_next, clk, arst_n, stat.idle, stat.base_le_next, "base past next")
	`ASW_ASSERT_IMP(a_push_free, clk, arst_n, push_vld, out_free, "push into full stage")
	`ASW_ASSERT_NXT(a_restart_base, clk, arst_n, restart_acc, stat.base_zero, "base not cleared")

endmodule
